FILE: rtl/tcce_pkg.sv
// shared types, codes and helpers of the text console cursor engine
package tcce_pkg;

  // input transaction kinds
  typedef enum logic [1:0] {
    KIND_PUT       = 2'd0,
    KIND_BACKSPACE = 2'd1,
    KIND_CLEAR     = 2'd2
  } kind_t;

  // drawing command codes
  typedef enum logic [1:0] {
    OP_DRAW   = 2'd0,
    OP_BLANK  = 2'd1,
    OP_SCROLL = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_COLUMNS     = 3'd0,
    REG_ROWS        = 3'd1,
    REG_CELL_WIDTH  = 3'd2,
    REG_CELL_HEIGHT = 3'd3,
    REG_FORE_COLOR  = 3'd4,
    REG_BACK_COLOR  = 3'd5
  } reg_idx_t;

  // control characters
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_TAB = 8'd9;

  // reset values of the registers
  localparam logic [9:0]  COLUMNS_RST     = 10'd128;
  localparam logic [8:0]  ROWS_RST        = 9'd48;
  localparam logic [6:0]  CELL_WIDTH_RST  = 7'd8;
  localparam logic [6:0]  CELL_HEIGHT_RST = 7'd16;
  localparam logic [31:0] FORE_COLOR_RST  = 32'h00CC_CCCC;
  localparam logic [31:0] BACK_COLOR_RST  = 32'h0000_0000;

  // limits applied when a register is used
  localparam logic [9:0] COLUMNS_MAX = 10'd512;
  localparam logic [8:0] ROWS_MAX    = 9'd256;
  localparam logic [6:0] CELL_MAX    = 7'd64;

  // packed output payload width, rounded up to whole bytes
  localparam int OUT_DATA_W = 104;

  typedef struct packed {
    logic [9:0]  columns;
    logic [8:0]  rows;
    logic [6:0]  cell_width;
    logic [6:0]  cell_height;
    logic [31:0] fore_color;
    logic [31:0] back_color;
  } cfg_t;

  typedef struct packed {
    logic [9:0] col;
    logic [7:0] row;
  } cursor_t;

  typedef struct packed {
    op_t         op;
    logic [14:0] x_pixel;
    logic [13:0] y_pixel;
    logic [7:0]  glyph;
    logic [31:0] fg_out;
    logic [31:0] bg_out;
    logic        last;
  } res_t;

  function automatic logic [9:0] clamp_columns(input logic [9:0] v);
    logic [9:0] r;
    if (v == 10'd0) begin
      r = 10'd1;
    end else if (v > COLUMNS_MAX) begin
      r = COLUMNS_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [8:0] clamp_rows(input logic [8:0] v);
    logic [8:0] r;
    if (v == 9'd0) begin
      r = 9'd1;
    end else if (v > ROWS_MAX) begin
      r = ROWS_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic [6:0] clamp_cell(input logic [6:0] v);
    logic [6:0] r;
    if (v == 7'd0) begin
      r = 7'd1;
    end else if (v > CELL_MAX) begin
      r = CELL_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/text_console_cursor_engine_unit.sv
// top level of the text console cursor engine: registers, input stage and result queue
//
// channel  direction  handshake          payload
// s_*      in         s_tvalid/s_tready  tuser: kind; tdata: ch
// m_*      out        m_tvalid/m_tready  tuser: op; tdata: x, y, glyph, fg, bg; tlast: last
// apb      in         psel/penable       six registers at byte address 4*index
//
// an event waits in the input register until the queue has room, then its results are registered into the queue
// one result leaves per cycle while m_tready is high, so an event with a scroll and a draw gives two results
// the two-entry result queue limits the rate; events without results never wait
// rst (synchronous) clears the cursor, both stages and loads register reset values
// a stalled output keeps accepting events while the queue has room for their results
module text_console_cursor_engine_unit (
  input  logic        clk,
  input  logic        rst,
  // input events
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic [1:0]  s_tuser,   // [1:0] kind
  // drawing commands
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [tcce_pkg::OUT_DATA_W-1:0] m_tdata, // x_pixel, y_pixel, glyph, fg_out, bg_out
  output logic [1:0]  m_tuser,   // [1:0] op
  output logic        m_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  tcce_pkg::cfg_t    cfg;
  tcce_pkg::cursor_t cur;
  tcce_pkg::cursor_t cur_next;
  logic              in_valid;
  logic [1:0]        in_kind;
  logic [7:0]        in_ch;
  tcce_pkg::res_t    res0;
  tcce_pkg::res_t    res1;
  logic [1:0]        n;
  logic              process;
  tcce_pkg::res_t    q [2];
  tcce_pkg::res_t    q_next [2];
  logic [1:0]        count;
  logic [1:0]        count_next;
  logic [1:0]        base;
  logic              pop;
  logic              cfg_wr;
  logic [2:0]        reg_idx;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.columns     <= tcce_pkg::COLUMNS_RST;
      cfg.rows        <= tcce_pkg::ROWS_RST;
      cfg.cell_width  <= tcce_pkg::CELL_WIDTH_RST;
      cfg.cell_height <= tcce_pkg::CELL_HEIGHT_RST;
      cfg.fore_color  <= tcce_pkg::FORE_COLOR_RST;
      cfg.back_color  <= tcce_pkg::BACK_COLOR_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        tcce_pkg::REG_COLUMNS:     cfg.columns     <= pwdata[9:0];
        tcce_pkg::REG_ROWS:        cfg.rows        <= pwdata[8:0];
        tcce_pkg::REG_CELL_WIDTH:  cfg.cell_width  <= pwdata[6:0];
        tcce_pkg::REG_CELL_HEIGHT: cfg.cell_height <= pwdata[6:0];
        tcce_pkg::REG_FORE_COLOR:  cfg.fore_color  <= pwdata;
        tcce_pkg::REG_BACK_COLOR:  cfg.back_color  <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      tcce_pkg::REG_COLUMNS:     prdata = {22'd0, cfg.columns};
      tcce_pkg::REG_ROWS:        prdata = {23'd0, cfg.rows};
      tcce_pkg::REG_CELL_WIDTH:  prdata = {25'd0, cfg.cell_width};
      tcce_pkg::REG_CELL_HEIGHT: prdata = {25'd0, cfg.cell_height};
      tcce_pkg::REG_FORE_COLOR:  prdata = cfg.fore_color;
      tcce_pkg::REG_BACK_COLOR:  prdata = cfg.back_color;
      default:                   prdata = 32'd0;
    endcase
  end

  // event decode and cursor arithmetic
  tcce_step u_step (
    .kind     (in_kind),
    .ch       (in_ch),
    .cur      (cur),
    .cfg      (cfg),
    .cur_next (cur_next),
    .res0     (res0),
    .res1     (res1),
    .n        (n)
  );

  // an event proceeds once the queue has room for all of its results
  assign process  = in_valid && ({1'b0, n} + {1'b0, count} <= 3'd2);
  assign s_tready = !in_valid || process;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_kind <= s_tuser;
      in_ch   <= s_tdata;
    end
  end

  // cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (process) begin
      cur <= cur_next;
    end
  end

  // result queue: pop the head, then append new results behind what is left
  assign m_tvalid = (count != 2'd0);
  assign pop      = m_tvalid && m_tready;
  assign base     = pop ? count - 2'd1 : count;

  always_comb begin
    q_next[0]  = pop ? q[1] : q[0];
    q_next[1]  = q[1];
    count_next = base;
    if (process) begin
      count_next = base + n;
      if (n != 2'd0) begin
        if (base == 2'd0) begin
          q_next[0] = res0;
        end else begin
          q_next[1] = res0;
        end
      end
      if (n == 2'd2) begin
        q_next[1] = res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    q[0] <= q_next[0];
    q[1] <= q_next[1];
  end

  // output packing
  assign m_tuser = q[0].op;
  assign m_tlast = q[0].last;
  assign m_tdata = {3'd0, q[0].bg_out, q[0].fg_out, q[0].glyph,
                    q[0].y_pixel, q[0].x_pixel};

  // queue never overfills
  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("result queue overflow");

  // a result that is not the last of its event is always followed by another
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("missing final result of an event");

  // draw, blank and clear are always the final result of their event
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == tcce_pkg::OP_DRAW || m_tuser == tcce_pkg::OP_BLANK ||
                 m_tuser == tcce_pkg::OP_CLEAR) |-> m_tlast)
    else $error("cell command not marked last");

  // clearing the screen homes the cursor
  assert property (@(posedge clk) disable iff (rst)
    process && in_kind == tcce_pkg::KIND_CLEAR |=> cur.col == 10'd0 && cur.row == 8'd0)
    else $error("cursor not homed after clear");

endmodule

FILE: rtl/tcce_step.sv
// cursor update and drawing command generation for one console event
module tcce_step (
  input  logic [1:0]       kind,
  input  logic [7:0]       ch,
  input  tcce_pkg::cursor_t cur,
  input  tcce_pkg::cfg_t   cfg,
  output tcce_pkg::cursor_t cur_next,
  output tcce_pkg::res_t   res0,
  output tcce_pkg::res_t   res1,
  output logic [1:0]       n
);

  logic [9:0]  ncols;
  logic [8:0]  nrows;
  logic [8:0]  nrows_m1;
  logic [6:0]  cw;
  logic [6:0]  chh;
  logic [8:0]  row_inc;
  logic        lf_scroll;
  logic [7:0]  lf_row;
  logic [10:0] tab_col;
  logic        scroll;
  logic        emit_cell;
  logic        clear;
  tcce_pkg::op_t cell_op;
  logic [9:0]  col_d;
  logic [7:0]  row_d;
  logic [16:0] x_prod;
  logic [14:0] y_prod;
  tcce_pkg::res_t scroll_res;
  tcce_pkg::res_t cell_res;
  tcce_pkg::res_t clear_res;

  // clamped geometry
  assign ncols    = tcce_pkg::clamp_columns(cfg.columns);
  assign nrows    = tcce_pkg::clamp_rows(cfg.rows);
  assign nrows_m1 = nrows - 9'd1;
  assign cw       = tcce_pkg::clamp_cell(cfg.cell_width);
  assign chh      = tcce_pkg::clamp_cell(cfg.cell_height);

  // move to the next row, scrolling when it leaves the screen
  assign row_inc   = {1'b0, cur.row} + 9'd1;
  assign lf_scroll = (row_inc >= nrows);
  assign lf_row    = lf_scroll ? nrows_m1[7:0] : row_inc[7:0];

  // next tab stop on a multiple of four
  assign tab_col = ({1'b0, cur.col} + 11'd4) & ~11'd3;

  // cursor movement and target cell
  always_comb begin
    scroll    = 1'b0;
    emit_cell = 1'b0;
    clear     = 1'b0;
    cell_op   = tcce_pkg::OP_DRAW;
    col_d     = cur.col;
    row_d     = cur.row;
    cur_next  = cur;
    case (kind)
      tcce_pkg::KIND_PUT: begin
        if (ch == tcce_pkg::CH_LF) begin
          scroll       = lf_scroll;
          cur_next.col = 10'd0;
          cur_next.row = lf_row;
        end else if (ch == tcce_pkg::CH_TAB) begin
          if (tab_col >= {1'b0, ncols}) begin
            scroll       = lf_scroll;
            cur_next.col = 10'd0;
            cur_next.row = lf_row;
          end else begin
            cur_next.col = tab_col[9:0];
          end
        end else begin
          // wrap before drawing when the cursor is past the line end
          if (cur.col >= ncols) begin
            scroll = lf_scroll;
            col_d  = 10'd0;
            row_d  = lf_row;
          end
          emit_cell    = 1'b1;
          cell_op      = tcce_pkg::OP_DRAW;
          cur_next.col = col_d + 10'd1;
          cur_next.row = row_d;
        end
      end
      tcce_pkg::KIND_BACKSPACE: begin
        cell_op = tcce_pkg::OP_BLANK;
        if (cur.col == 10'd0) begin
          // at the origin nothing happens
          if (cur.row != 8'd0) begin
            emit_cell = 1'b1;
            row_d     = cur.row - 8'd1;
            col_d     = ncols - 10'd1;
          end
        end else begin
          emit_cell = 1'b1;
          col_d     = cur.col - 10'd1;
        end
        cur_next.col = col_d;
        cur_next.row = row_d;
      end
      tcce_pkg::KIND_CLEAR: begin
        clear    = 1'b1;
        cur_next = '0;
      end
      default: begin
      end
    endcase
  end

  // pixel position of the target cell
  assign x_prod = {7'd0, col_d} * {10'd0, cw};
  assign y_prod = {7'd0, row_d} * {8'd0, chh};

  // candidate commands
  always_comb begin
    scroll_res        = '0;
    scroll_res.op     = tcce_pkg::OP_SCROLL;
    scroll_res.bg_out = cfg.back_color;
    scroll_res.last   = !emit_cell;

    cell_res         = '0;
    cell_res.op      = cell_op;
    cell_res.x_pixel = x_prod[14:0];
    cell_res.y_pixel = y_prod[13:0];
    cell_res.glyph   = (cell_op == tcce_pkg::OP_DRAW) ? ch : 8'd0;
    cell_res.fg_out  = (cell_op == tcce_pkg::OP_DRAW) ? cfg.fore_color : 32'd0;
    cell_res.bg_out  = cfg.back_color;
    cell_res.last    = 1'b1;

    clear_res      = '0;
    clear_res.op   = tcce_pkg::OP_CLEAR;
    clear_res.last = 1'b1;
  end

  // order the results, scroll ahead of the cell it makes room for
  always_comb begin
    res0 = cell_res;
    res1 = cell_res;
    n    = 2'd0;
    if (clear) begin
      res0 = clear_res;
      n    = 2'd1;
    end else if (scroll && emit_cell) begin
      res0 = scroll_res;
      n    = 2'd2;
    end else if (scroll) begin
      res0 = scroll_res;
      n    = 2'd1;
    end else if (emit_cell) begin
      n = 2'd1;
    end
  end

endmodule
